>>> rtl/assert_macros.svh
// assertion macros used by the top rtl file
// no dependencies; synthesis builds see empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define CB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// antecedent one cycle, consequent the next
`define CB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CB_ASSERT(lbl, clk, rstn, prop, msg)
`define CB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/cbsvm_pkg.sv
// shared types, constants and fixed point helpers for the color box svm scorer
// no dependencies
package cbsvm_pkg;

    localparam int NumFeatures   = 136;
    localparam int CoeffFracBits = 16;
    localparam int RomSize       = 136;
    localparam int RomFrac       = 16;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 8;

    // register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] CfgLumaLow  = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgLumaHigh = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgCbLow    = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgCbHigh   = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgCrLow    = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgCrHigh   = 3'd5;

    typedef struct packed {
        logic [7:0] luma_low;
        logic [7:0] luma_high;
        logic [7:0] cb_low;
        logic [7:0] cb_high;
        logic [7:0] cr_low;
        logic [7:0] cr_high;
    } t_box_cfg;

    // coefficients held with RomFrac fraction bits
    localparam int CoefRom [0:RomSize-1] = '{
        -19208, 18711, -57774, 0, 0, 0, 0, -21873, 15627, -10081,
        15682, 0, 0, 0, 0, 0, -37242, 30460, 15682, 0,
        0, 4716, 0, 0, 9605, 32330, 42509, 43506, 54291, 0,
        17799, 0, -24570, 16396, 53201, 63031, 0, 0, 9512, 0,
        77766, 5731, 25724, -25017, -56555, -23893, 0, 0, 52962, -9876,
        -8064, 43506, 27824, 0, 0, 0, 41399, 34307, -34428, 22867,
        -23981, -32665, -72873, -4591, 80926, -7619, 8290, -9798, 16838, -8424,
        0, -32665, 66534, -72472, -5245, -10040, 41379, -32665, -4349, 45728,
        56479, 38031, -9712, 7185, -42163, -74202, -242, -64213, 80173, -23591,
        -25187, -48084, -28735, 10692, -27606, -242, 56911, -34209, 4721, -4957,
        -25317, -242, 0, 0, 51547, 74268, -1224, -24988, 0, -4797,
        0, -33739, 23229, 9540, 20258, 15682, 0, -25437, -21873, 0,
        -25662, 21011, -5545, 48346, 15593, -41528, -25437, 0, -25672, 16424,
        5098, 0, 0, 0, 0, 0
    };

    localparam int InterceptRom = -476990;

    localparam int ShiftUp = (CoeffFracBits > RomFrac) ? (CoeffFracBits - RomFrac) : 0;
    localparam int ShiftDn = (CoeffFracBits < RomFrac) ? (RomFrac - CoeffFracBits) : 0;
    localparam logic [63:0] RoundHalf = (ShiftDn > 0) ? (64'd1 << (ShiftDn - 1)) : 64'd0;

    // move a rom value to CoeffFracBits, rounding half away from zero
    function automatic logic signed [31:0] rescale(input int v);
        logic [63:0] mag;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        mag = mag << ShiftUp;
        mag = (mag + RoundHalf) >> ShiftDn;
        return (v < 0) ? -$signed(mag[31:0]) : $signed(mag[31:0]);
    endfunction

    // 32 bit add clamped to the signed range
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[31:0];
    endfunction

    // coefficient for one feature index, zero beyond the table
    function automatic logic signed [31:0] coef_at(input logic [7:0] idx);
        if (int'(idx) < NumFeatures && int'(idx) < RomSize) begin
            return rescale(CoefRom[idx]);
        end
        return 32'sd0;
    endfunction

endpackage

>>> rtl/cbsvm_accum.sv
// box test, coefficient lookup and saturating running sum
// depends on cbsvm_pkg
module cbsvm_accum (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cbsvm_pkg::t_box_cfg  i_cfg,
    input  logic                 i_fire,
    input  logic [7:0]           i_luma,
    input  logic [7:0]           i_blue_diff,
    input  logic [7:0]           i_red_diff,
    input  logic [7:0]           i_feature_index,
    input  logic                 i_frame_end,
    output logic signed [31:0]   o_score,
    output logic signed [31:0]   o_sum
);

    logic               in_box;
    logic signed [31:0] add_val;
    logic signed [31:0] sum_new;
    logic signed [31:0] r_sum;
    logic signed [31:0] n_sum;

    assign in_box = (i_luma >= i_cfg.luma_low) && (i_luma <= i_cfg.luma_high) &&
                    (i_blue_diff >= i_cfg.cb_low) && (i_blue_diff <= i_cfg.cb_high) &&
                    (i_red_diff >= i_cfg.cr_low) && (i_red_diff <= i_cfg.cr_high);

    assign add_val = in_box ? cbsvm_pkg::coef_at(i_feature_index) : 32'sd0;
    assign sum_new = cbsvm_pkg::sat_add(r_sum, add_val);
    assign o_score = cbsvm_pkg::sat_add(sum_new,
                                        cbsvm_pkg::rescale(cbsvm_pkg::InterceptRom));
    assign o_sum   = r_sum;

    // sum starts over after the last sample of a frame
    always_comb begin
        n_sum = r_sum;
        if (i_fire) begin
            n_sum = i_frame_end ? 32'sd0 : sum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 32'sd0;
        end else begin
            r_sum <= n_sum;
        end
    end

endmodule

>>> rtl/color_box_linear_svm_classifier.sv
// Color box linear SVM scorer, valid/ready on both sides. Takes one sample per
// clock cycle; an unclaimed result stalls the next frame_end sample and those
// behind it, while earlier ones flow on. A sample is held in an input register,
// then box test, coefficient lookup and the saturating accumulate run
// combinationally on it; for the sample marked frame_end the score and decision
// are registered as it leaves the input register. The critical path is the
// accumulate (sum plus coefficient, then plus intercept). Configuration writes
// take effect on the next edge and are meant for idle time.
`include "assert_macros.svh"

module color_box_linear_svm_classifier (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [cbsvm_pkg::CfgIdxW-1:0]          i_cfg_index,
    input  logic [cbsvm_pkg::CfgDataW-1:0]         i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [7:0]                             i_luma,
    input  logic [7:0]                             i_blue_diff,
    input  logic [7:0]                             i_red_diff,
    input  logic [7:0]                             i_feature_index,
    input  logic                                   i_frame_end,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [31:0]                     o_score,
    output logic                                   o_decision
);

    cbsvm_pkg::t_box_cfg r_cfg;

    logic               r_in_valid;
    logic [7:0]         r_luma;
    logic [7:0]         r_cb;
    logic [7:0]         r_cr;
    logic [7:0]         r_idx;
    logic               r_last;

    logic               r_out_valid;
    logic signed [31:0] r_score;
    logic               r_decision;

    logic               s1_fire;
    logic signed [31:0] score_next;
    logic signed [31:0] sum_now;

    // a frame end sample waits while the previous result is still unclaimed
    assign s1_fire = r_in_valid && !(r_last && r_out_valid && !i_ready);
    assign o_ready = !r_in_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.luma_low  <= 8'd0;
            r_cfg.luma_high <= 8'd255;
            r_cfg.cb_low    <= 8'd0;
            r_cfg.cb_high   <= 8'd255;
            r_cfg.cr_low    <= 8'd0;
            r_cfg.cr_high   <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cbsvm_pkg::CfgLumaLow:  r_cfg.luma_low  <= i_cfg_data;
                cbsvm_pkg::CfgLumaHigh: r_cfg.luma_high <= i_cfg_data;
                cbsvm_pkg::CfgCbLow:    r_cfg.cb_low    <= i_cfg_data;
                cbsvm_pkg::CfgCbHigh:   r_cfg.cb_high   <= i_cfg_data;
                cbsvm_pkg::CfgCrLow:    r_cfg.cr_low    <= i_cfg_data;
                cbsvm_pkg::CfgCrHigh:   r_cfg.cr_high   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_luma <= i_luma;
            r_cb   <= i_blue_diff;
            r_cr   <= i_red_diff;
            r_idx  <= i_feature_index;
            r_last <= i_frame_end;
        end
    end

    cbsvm_accum u_accum (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_fire          (s1_fire),
        .i_luma          (r_luma),
        .i_blue_diff     (r_cb),
        .i_red_diff      (r_cr),
        .i_feature_index (r_idx),
        .i_frame_end     (r_last),
        .o_score         (score_next),
        .o_sum           (sum_now)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_last) begin
            r_score    <= score_next;
            r_decision <= (score_next > 32'sd0);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_score    = r_score;
    assign o_decision = r_decision;

    // a pending result must never be overwritten by the next frame end
    `CB_ASSERT(a_no_overwrite, i_clk, i_rst_n,
        !(s1_fire && r_last && r_out_valid && !i_ready), "result overwritten")

    // the running sum restarts after every frame end transfer
    `CB_ASSERT_NEXT(a_sum_cleared, i_clk, i_rst_n, s1_fire && r_last,
        sum_now == 32'sd0, "sum not cleared after frame end")

    // decision bit agrees with the sign of the held score
    `CB_ASSERT(a_decision_sign, i_clk, i_rst_n,
        !o_valid || (o_decision == (o_score > 32'sd0)), "decision mismatch")

endmodule

>>> test/color_box_linear_svm_classifier_test.sv
// testbench for color_box_linear_svm_classifier: random and directed frames of yuv samples
// under valid/ready idling, scored by an in-bench predictor of the box test and fixed point sum
// depends on rtl/cbsvm_pkg.sv and the classifier rtl
module color_box_linear_svm_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit   = 400000;
    localparam int SettleCycles = 8;
    localparam int ScoreFrac    = 16;
    localparam int TableFrac    = 16;
    localparam int CoefCount    = 136;

    // largest positive and most negative coefficients, repeated to build large sums
    localparam logic [7:0] PeakCoefIdx = 8'd64;
    localparam logic [7:0] DeepCoefIdx = 8'd85;
    localparam int         RunToMax    = 12;
    localparam int         RunToMin    = 12;

    // register indexes with no register behind them
    localparam logic [cbsvm_pkg::CfgIdxW-1:0] CfgSpareA = 3'd6;
    localparam logic [cbsvm_pkg::CfgIdxW-1:0] CfgSpareB = 3'd7;

    localparam int SvmCoef [0:CoefCount-1] = '{
        -19208, 18711, -57774, 0, 0, 0, 0, -21873, 15627, -10081,
        15682, 0, 0, 0, 0, 0, -37242, 30460, 15682, 0,
        0, 4716, 0, 0, 9605, 32330, 42509, 43506, 54291, 0,
        17799, 0, -24570, 16396, 53201, 63031, 0, 0, 9512, 0,
        77766, 5731, 25724, -25017, -56555, -23893, 0, 0, 52962, -9876,
        -8064, 43506, 27824, 0, 0, 0, 41399, 34307, -34428, 22867,
        -23981, -32665, -72873, -4591, 80926, -7619, 8290, -9798, 16838, -8424,
        0, -32665, 66534, -72472, -5245, -10040, 41379, -32665, -4349, 45728,
        56479, 38031, -9712, 7185, -42163, -74202, -242, -64213, 80173, -23591,
        -25187, -48084, -28735, 10692, -27606, -242, 56911, -34209, 4721, -4957,
        -25317, -242, 0, 0, 51547, 74268, -1224, -24988, 0, -4797,
        0, -33739, 23229, 9540, 20258, 15682, 0, -25437, -21873, 0,
        -25662, 21011, -5545, 48346, 15593, -41528, -25437, 0, -25672, 16424,
        5098, 0, 0, 0, 0, 0
    };
    localparam int SvmIntercept = -476990;

    typedef enum int {FrameOrdered, FrameFull, FrameNoise} t_frame_kind;

    typedef struct {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
        logic [7:0] idx;
        logic       last;
    } t_pixel;

    typedef struct {
        logic signed [31:0] score;
        logic               decision;
    } t_score;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [cbsvm_pkg::CfgIdxW-1:0]     i_cfg_index = '0;
    logic [cbsvm_pkg::CfgDataW-1:0]    i_cfg_data = '0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic [7:0]                        i_luma = '0;
    logic [7:0]                        i_blue_diff = '0;
    logic [7:0]                        i_red_diff = '0;
    logic [7:0]                        i_feature_index = '0;
    logic                              i_frame_end = 1'b0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic signed [31:0]                o_score;
    logic                              o_decision;

    t_pixel               pending_pixels[$];
    t_score               expected_scores[$];
    cbsvm_pkg::t_box_cfg  box = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
    logic signed [31:0]   frame_sum = '0;
    bit                   pixel_taken = 1'b0;
    bit                   idle_on = 1'b1;
    int                   send_gap = 0;
    int                   take_gap = 0;
    int                   mismatches = 0;
    int                   n_pixels = 0;
    int                   n_scores = 0;
    int                   n_settings = 0;
    int                   cycle_count = 0;

    color_box_linear_svm_classifier uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_luma          (i_luma),
        .i_blue_diff     (i_blue_diff),
        .i_red_diff      (i_red_diff),
        .i_feature_index (i_feature_index),
        .i_frame_end     (i_frame_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_score         (o_score),
        .o_decision      (o_decision)
    );

    always #2 i_clk = ~i_clk;

    // coefficient moved from table fraction bits to score fraction bits, ties away from zero
    function automatic logic signed [31:0] scale_coef(input int v);
        longint mag;
        int up;
        int dn;
        up = ScoreFrac - TableFrac;
        dn = TableFrac - ScoreFrac;
        mag = (v < 0) ? -longint'(v) : longint'(v);
        if (up > 0) begin
            mag = mag <<< up;
        end
        if (dn > 0) begin
            mag = (mag + (longint'(1) <<< (dn - 1))) >>> dn;
        end
        if (v < 0) begin
            mag = -mag;
        end
        return 32'(mag);
    endfunction

    function automatic logic signed [31:0] add_clamped(input logic signed [31:0] a,
                                                       input logic signed [31:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > longint'(32'sh7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end
        if (s < longint'(32'sh8000_0000)) begin
            return 32'sh8000_0000;
        end
        return 32'(s);
    endfunction

    // mostly inside the window, sometimes on or just past an edge, sometimes anywhere
    function automatic logic [7:0] pick_level(input logic [7:0] lo, input logic [7:0] hi);
        int r;
        r = $urandom_range(0, 7);
        if (r < 5 && lo <= hi) begin
            return 8'($urandom_range(int'(hi), int'(lo)));
        end
        if (r == 5) begin
            return ($urandom_range(0, 1) != 0) ? lo : hi;
        end
        if (r == 6) begin
            return ($urandom_range(0, 1) != 0) ? 8'(lo - 8'd1) : 8'(hi + 8'd1);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_px(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr,
                           input logic [7:0] idx, input logic last);
        t_pixel px;
        px = '{y, cb, cr, idx, last};
        pending_pixels.push_back(px);
    endtask

    task automatic push_random_px(input logic [7:0] idx, input logic last);
        push_px(pick_level(box.luma_low, box.luma_high), pick_level(box.cb_low, box.cb_high),
                pick_level(box.cr_low, box.cr_high), idx, last);
    endtask

    task automatic write_reg(input logic [cbsvm_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            cbsvm_pkg::CfgLumaLow:  box.luma_low  = val;
            cbsvm_pkg::CfgLumaHigh: box.luma_high = val;
            cbsvm_pkg::CfgCbLow:    box.cb_low    = val;
            cbsvm_pkg::CfgCbHigh:   box.cb_high   = val;
            cbsvm_pkg::CfgCrLow:    box.cr_low    = val;
            cbsvm_pkg::CfgCrHigh:   box.cr_high   = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_box(input logic [7:0] yl, input logic [7:0] yh, input logic [7:0] bl,
                           input logic [7:0] bh, input logic [7:0] rl, input logic [7:0] rh);
        write_reg(cbsvm_pkg::CfgLumaLow, yl);
        write_reg(cbsvm_pkg::CfgLumaHigh, yh);
        write_reg(cbsvm_pkg::CfgCbLow, bl);
        write_reg(cbsvm_pkg::CfgCbHigh, bh);
        write_reg(cbsvm_pkg::CfgCrLow, rl);
        write_reg(cbsvm_pkg::CfgCrHigh, rh);
        n_settings++;
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || i_valid || expected_scores.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // frames of at least n_items samples in total; every phase ends on a frame end
    task automatic queue_frames(input int n_items);
        int          added;
        int          idx;
        int          len;
        int          r;
        t_frame_kind kind;
        int          picks[$];
        added = 0;
        while (added < n_items) begin
            r = $urandom_range(0, 19);
            kind = (r < 15) ? FrameOrdered : (r == 15) ? FrameFull : FrameNoise;
            picks.delete();
            case (kind)
                FrameOrdered: begin
                    len = $urandom_range(1, 20);
                    idx = $urandom_range(0, 20);
                    while (picks.size() < len && idx < CoefCount) begin
                        picks.push_back(idx);
                        idx += $urandom_range(1, 12);
                    end
                end
                FrameFull: begin
                    for (int i = 0; i < CoefCount; i++) begin
                        picks.push_back(i);
                    end
                end
                default: begin
                    len = $urandom_range(1, 12);
                    repeat (len) picks.push_back($urandom_range(0, 255));
                end
            endcase
            foreach (picks[i]) begin
                push_random_px(8'(picks[i]), (i == picks.size() - 1) ||
                               (kind == FrameNoise && $urandom_range(0, 5) == 0));
            end
            added += picks.size();
        end
    endtask

    // predictor: box test and clamped accumulate on every transfer in
    always @(posedge i_clk) begin
        t_score             res;
        logic signed [31:0] total;
        logic               in_box;
        pixel_taken = i_rst_n && i_valid && o_ready;
        if (pixel_taken) begin
            n_pixels++;
            in_box = i_luma >= box.luma_low && i_luma <= box.luma_high &&
                     i_blue_diff >= box.cb_low && i_blue_diff <= box.cb_high &&
                     i_red_diff >= box.cr_low && i_red_diff <= box.cr_high;
            if (in_box && int'(i_feature_index) < cbsvm_pkg::NumFeatures &&
                    int'(i_feature_index) < CoefCount) begin
                frame_sum = add_clamped(frame_sum, scale_coef(SvmCoef[i_feature_index]));
            end
            if (i_frame_end) begin
                total = add_clamped(frame_sum, scale_coef(SvmIntercept));
                res.score    = total;
                res.decision = total > 0;
                expected_scores.push_back(res);
                frame_sum = '0;
            end
        end
    end

    // sample driver with random idle bursts
    always @(negedge i_clk) begin
        t_pixel px;
        logic   next_valid;
        if (!i_valid || pixel_taken) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 12) - 1;
            end else if (pending_pixels.size() > 0) begin
                px = pending_pixels.pop_front();
                i_luma          <= px.luma;
                i_blue_diff     <= px.cb;
                i_red_diff      <= px.cr;
                i_feature_index <= px.idx;
                i_frame_end     <= px.last;
                next_valid = 1'b1;
            end
            i_valid <= next_valid;
        end
    end

    // result side stalls
    always @(negedge i_clk) begin
        if (take_gap > 0) begin
            take_gap--;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            take_gap = $urandom_range(1, 12) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_score want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_scores.size() == 0) begin
                $error("score transfer with nothing expected: score=%0d decision=%0b",
                       o_score, o_decision);
                mismatches++;
            end else begin
                want = expected_scores.pop_front();
                n_scores++;
                if (o_score !== want.score) begin
                    $error("score: expected %0d, actual %0d", want.score, o_score);
                    mismatches++;
                end
                if (o_decision !== want.decision) begin
                    $error("decision: expected %0b, actual %0b", want.decision, o_decision);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $error("timeout after %0d cycles, %0d scores outstanding", cycle_count,
                   expected_scores.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [7:0] lo [3];
        logic [7:0] hi [3];
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset box: extremes, out of range and repeated indices
        push_px(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        push_px(8'd255, 8'd255, 8'd255, 8'd135, 1'b0);
        push_px(8'd128, 8'd128, 8'd128, 8'd136, 1'b0);
        push_px(8'd1, 8'd2, 8'd3, 8'd255, 1'b0);
        push_px(8'd10, 8'd20, 8'd30, 8'd0, 1'b0);
        push_px(8'd200, 8'd100, 8'd50, 8'd2, 1'b1);
        // one-sample frame: intercept alone
        push_px(8'd77, 8'd77, 8'd77, 8'd3, 1'b1);
        // strong positive coefficients, enough to beat the intercept
        push_px(8'd90, 8'd91, 8'd92, 8'd64, 1'b0);
        push_px(8'd90, 8'd91, 8'd92, 8'd88, 1'b0);
        push_px(8'd90, 8'd91, 8'd92, 8'd40, 1'b0);
        push_px(8'd90, 8'd91, 8'd92, 8'd105, 1'b0);
        push_px(8'd90, 8'd91, 8'd92, 8'd72, 1'b0);
        push_px(8'd90, 8'd91, 8'd92, 8'd35, 1'b0);
        push_px(8'd90, 8'd91, 8'd92, 8'd96, 1'b1);
        wait_drained();

        // single-value luma window, samples on each limit and just past all but cr high
        set_box(8'd100, 8'd100, 8'd50, 8'd60, 8'd200, 8'd255);
        push_px(8'd100, 8'd55, 8'd220, 8'd64, 1'b0);
        push_px(8'd99, 8'd55, 8'd220, 8'd88, 1'b0);
        push_px(8'd101, 8'd55, 8'd220, 8'd40, 1'b0);
        push_px(8'd100, 8'd49, 8'd220, 8'd105, 1'b0);
        push_px(8'd100, 8'd50, 8'd200, 8'd72, 1'b0);
        push_px(8'd100, 8'd60, 8'd255, 8'd35, 1'b0);
        push_px(8'd100, 8'd61, 8'd220, 8'd96, 1'b0);
        push_px(8'd100, 8'd55, 8'd199, 8'd2, 1'b0);
        push_px(8'd100, 8'd55, 8'd255, 8'd64, 1'b1);
        wait_drained();

        // low above high: nothing can be inside
        set_box(8'd200, 8'd100, 8'd255, 8'd0, 8'd1, 8'd0);
        push_px(8'd150, 8'd128, 8'd0, 8'd64, 1'b0);
        push_px(8'd200, 8'd255, 8'd1, 8'd88, 1'b0);
        push_px(8'd100, 8'd0, 8'd0, 8'd40, 1'b1);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_box(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
                1: begin
                    set_box(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
                    write_reg(CfgSpareA, 8'($urandom));
                    write_reg(CfgSpareB, 8'($urandom));
                end
                2: set_box(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                default: begin
                    for (int c = 0; c < 3; c++) begin
                        lo[c] = 8'($urandom_range(0, 255));
                        // last setting may leave a window empty
                        hi[c] = (p == 5) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(255, int'(lo[c])));
                    end
                    set_box(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
                end
            endcase
            idle_on = (p != 3);
            queue_frames(70);
            wait_drained();
        end

        // closing part: no idling, then frames with long runs of one index of either sign
        idle_on = 1'b0;
        set_box(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
        queue_frames(30);
        repeat (RunToMax) push_random_px(PeakCoefIdx, 1'b0);
        repeat (5) push_random_px(DeepCoefIdx, 1'b0);
        push_random_px(8'd3, 1'b1);
        repeat (RunToMin) push_random_px(DeepCoefIdx, 1'b0);
        push_random_px(8'd255, 1'b1);
        wait_drained();

        $display("%0d samples transferred over %0d box settings, %0d scores checked",
                 n_pixels, n_settings, n_scores);
        $display("covered window edges, empty windows, stray and repeated indices");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/cbsvm_pkg.sv
rtl/cbsvm_accum.sv
rtl/color_box_linear_svm_classifier.sv
test/color_box_linear_svm_classifier_test.sv
